/* hdl/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants of the canonical Huffman bit decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  // Item kinds carried on the op field
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } chbd_op_e;

  localparam int unsigned LENGTH_SLOTS = 16;  // count bytes at the head of a table
  localparam int unsigned SLOT_W       = 4;   // index into the per-length tables
  localparam int unsigned CODE_W       = 16;  // gathered code bits
  localparam int unsigned FIRST_W      = 17;  // canonical first code, wraps here
  localparam int unsigned BASE_W       = 9;   // running symbol base, wraps here
  localparam int unsigned POS_W        = 9;   // load position
  localparam int unsigned IDX_W        = 10;  // symbol base plus offset
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;   // result queue entries

  // Front-to-back request: one beat per finished code
  typedef struct packed {
    logic valid;  // a result is due
    logic err;    // no symbol, report an error
  } chbd_fetch_t;

endpackage

/* hdl/chbd_ram.sv */
// ----------------------------------------------------------------------------
// chbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/chbd_front.sv */
// ----------------------------------------------------------------------------
// chbd_front
// Table builder and bit classifier: takes load and decode items, keeps the
// canonical length tables, writes symbols and issues symbol reads.
// ----------------------------------------------------------------------------
module chbd_front import chbd_pkg::*; #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned SYMBOL_COUNT    = 256,
  parameter int unsigned AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              op_i,
  input  logic              restart_load_i,
  input  logic [BYTE_W-1:0] table_byte_i,
  input  logic              code_bit_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [BYTE_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  output chbd_fetch_t       fetch_o
);

  localparam logic [POS_W-1:0] PosSlots = POS_W'(LENGTH_SLOTS);
  localparam logic [POS_W-1:0] PosLimit = POS_W'(LENGTH_SLOTS + SYMBOL_COUNT);
  localparam logic [IDX_W-1:0] IdxLimit = IDX_W'(SYMBOL_COUNT);
  localparam logic [4:0]       MaxLen   = 5'(MAX_CODE_LENGTH);

  logic [CODE_W-1:0]  accum_q, accum_d;
  logic [SLOT_W-1:0]  bits_q, bits_d;
  logic [BYTE_W-1:0]  count_q [LENGTH_SLOTS];
  logic [BYTE_W-1:0]  count_d [LENGTH_SLOTS];
  logic [FIRST_W-1:0] first_q [LENGTH_SLOTS];
  logic [FIRST_W-1:0] first_d [LENGTH_SLOTS];
  logic [BASE_W-1:0]  base_q  [LENGTH_SLOTS];
  logic [BASE_W-1:0]  base_d  [LENGTH_SLOTS];
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [FIRST_W-1:0] nfc_q, nfc_d;
  logic [BASE_W-1:0]  nsb_q, nsb_d;
  chbd_fetch_t        fetch_q, fetch_d;

  logic [POS_W-1:0]   pos_eff;
  logic [FIRST_W-1:0] nfc_eff;
  logic [BASE_W-1:0]  nsb_eff;
  logic [CODE_W-1:0]  accum_n;
  logic [FIRST_W-1:0] offset;
  logic [IDX_W-1:0]   idx;
  logic               hit;

  always_comb begin
    accum_d     = accum_q;
    bits_d      = bits_q;
    count_d     = count_q;
    first_d     = first_q;
    base_d      = base_q;
    pos_d       = pos_q;
    nfc_d       = nfc_q;
    nsb_d       = nsb_q;
    fetch_d     = '0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_waddr_o = '0;
    mem_raddr_o = '0;

    pos_eff = restart_load_i ? '0 : pos_q;
    nfc_eff = restart_load_i ? '0 : nfc_q;
    nsb_eff = restart_load_i ? '0 : nsb_q;

    accum_n = {accum_q[CODE_W-2:0], code_bit_i};
    offset  = {1'b0, accum_n} - first_q[bits_q];
    hit     = (count_q[bits_q] != '0) && ({1'b0, accum_n} >= first_q[bits_q]) &&
              (offset < FIRST_W'(count_q[bits_q]));
    idx     = IDX_W'(base_q[bits_q]) + IDX_W'(offset[BYTE_W-1:0]);

    if (accept_i) begin
      if (op_i == OP_LOAD) begin
        // Any load byte drops a partial code
        accum_d = '0;
        bits_d  = '0;
        if (restart_load_i) begin
          for (int i = 0; i < LENGTH_SLOTS; i++) begin
            count_d[i] = '0;
            first_d[i] = '0;
            base_d[i]  = '0;
          end
          pos_d = '0;
          nfc_d = '0;
          nsb_d = '0;
        end
        if (pos_eff < PosSlots) begin
          count_d[pos_eff[SLOT_W-1:0]] = table_byte_i;
          first_d[pos_eff[SLOT_W-1:0]] = nfc_eff;
          base_d[pos_eff[SLOT_W-1:0]]  = nsb_eff;
          nfc_d = (nfc_eff + FIRST_W'(table_byte_i)) << 1;
          nsb_d = nsb_eff + BASE_W'(table_byte_i);
          pos_d = pos_eff + POS_W'(1);
        end else if (pos_eff < PosLimit) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(pos_eff - PosSlots);
          pos_d       = pos_eff + POS_W'(1);
        end
      end else begin
        if (hit) begin
          accum_d       = '0;
          bits_d        = '0;
          fetch_d.valid = 1'b1;
          fetch_d.err   = !(idx < IdxLimit);
          mem_re_o      = (idx < IdxLimit);
          mem_raddr_o   = AW'(idx);
        end else if (({1'b0, bits_q} + 5'd1) >= MaxLen) begin
          accum_d       = '0;
          bits_d        = '0;
          fetch_d.valid = 1'b1;
          fetch_d.err   = 1'b1;
        end else begin
          accum_d = accum_n;
          bits_d  = bits_q + SLOT_W'(1);
        end
      end
    end
  end

  assign mem_wdata_o = table_byte_i;
  assign fetch_o     = fetch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      bits_q  <= '0;
      pos_q   <= '0;
      nfc_q   <= '0;
      nsb_q   <= '0;
      fetch_q <= '0;
      for (int i = 0; i < LENGTH_SLOTS; i++) begin
        count_q[i] <= '0;
        first_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else begin
      accum_q <= accum_d;
      bits_q  <= bits_d;
      pos_q   <= pos_d;
      nfc_q   <= nfc_d;
      nsb_q   <= nsb_d;
      fetch_q <= fetch_d;
      count_q <= count_d;
      first_q <= first_d;
      base_q  <= base_d;
    end
  end

endmodule

/* hdl/chbd_queue.sv */
// ----------------------------------------------------------------------------
// chbd_queue
// Small result queue: holds finished symbols until the consumer pops them.
// ----------------------------------------------------------------------------
module chbd_queue import chbd_pkg::*; #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [BYTE_W-1:0] symbol_i,
  input  logic              error_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [CW-1:0]     count_o,
  output logic [BYTE_W-1:0] symbol_o,
  output logic              error_o
);

  logic [BYTE_W-1:0] sym_q [DEPTH];
  logic              err_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_pop  = pop_i && !empty_o;
  assign symbol_o = sym_q[rd_q];
  assign error_o  = err_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sym_q[wr_q] <= symbol_i;
      err_q[wr_q] <= error_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/canonical_huffman_bit_decoder_unit.sv */
// Result path: a finishing decode bit shows on the result ports after its beat is
//   accepted, through the symbol RAM read register and then the result queue.
// Throughput: one item per cycle while full is low, load or decode; the symbol RAM
//   takes one write or one read per cycle and the length tables are checked combinationally.
// Reset: asynchronous, active low; clears the length tables, gather state,
//   load position and queue. The symbol RAM keeps its contents undefined.
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder_unit
// Canonical Huffman decoder with a JPEG-layout table, one code bit per beat.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_unit import chbd_pkg::*; #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned SYMBOL_COUNT    = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic              restart_load_i,
  input  logic [BYTE_W-1:0] table_byte_i,
  input  logic              code_bit_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] symbol_o,
  output logic              error_o
);

  localparam int unsigned AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  chbd_fetch_t       fetch;
  logic [CW-1:0]     q_count;
  logic [BYTE_W-1:0] res_symbol;
  logic [CW:0]       in_flight;

  // Hold off new beats once the queue plus the fetch stage could overflow.
  // The fetch stage always pushes, so reserve its slot ahead of time.
  assign in_flight = {1'b0, q_count} + (CW + 1)'(fetch.valid);
  assign full      = (in_flight >= (CW + 1)'(QUEUE_DEPTH - 1));
  assign accept    = push && !full;

  // Front: table build, bit gathering, match against canonical ranges
  chbd_front #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .AW              (AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .restart_load_i (restart_load_i),
    .table_byte_i   (table_byte_i),
    .code_bit_i     (code_bit_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .fetch_o        (fetch)
  );

  // Symbol store in canonical code order
  chbd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SYMBOL_COUNT),
    .AW    (AW)
  ) u_symbols (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Back: error results carry symbol zero; valid ones take the RAM data
  assign res_symbol = fetch.err ? '0 : mem_rdata;

  chbd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_results (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fetch.valid),
    .symbol_i (res_symbol),
    .error_i  (fetch.err),
    .pop_i    (pop),
    .empty_o  (empty),
    .count_o  (q_count),
    .symbol_o (symbol_o),
    .error_o  (error_o)
  );

endmodule

/* hdl/chbd_checker.sv */
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks of the decoder unit over time.
// ----------------------------------------------------------------------------
module chbd_checker import chbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [BYTE_W-1:0] symbol_o,
  input logic              error_o
);

  logic acc;
  assign acc = push && !full;

  // An error result never carries a symbol
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (symbol_o == '0))
    else $error("error result with nonzero symbol");

  // No result appears without an accepted beat still in the front or fetch stages, or one waiting
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !acc && !$past(acc)) |=> empty)
    else $error("result appeared without a source beat");

  // A waiting result is not dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

  // A waiting result keeps its value
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(symbol_o) && $stable(error_o)))
    else $error("waiting result changed");

endmodule

bind canonical_huffman_bit_decoder_unit chbd_checker u_chbd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .symbol_o (symbol_o),
  .error_o  (error_o)
);

/* tb/sv/canonical_huffman_bit_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder_unit_tb
// Drives table loads and code bits into the decoder through its queue-style
// handshake, predicts every symbol in a scoreboard and checks each beat.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chbd_pkg::*;

  localparam int unsigned MAX_CODE_LENGTH = 16;
  localparam int unsigned SYMBOL_COUNT    = 256;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned TAIL_CYCLES     = 8;     // drain margin after the last result
  localparam int unsigned QUIET_LIMIT     = 4000;  // cycles with no beat on either side
  localparam int unsigned PHASE_BEATS     = 175;

  // One input beat as seen on the ports
  typedef struct packed {
    chbd_op_e          op;
    logic              restart_load;
    logic [BYTE_W-1:0] table_byte;
    logic              code_bit;
  } table_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the length tables and symbol memory, queues the
  // symbols that accepted beats must produce and checks the result beats.
  // --------------------------------------------------------------------------
  class chbd_symbol_scoreboard;
    typedef struct packed {
      logic [BYTE_W-1:0] symbol;
      logic              error;
    } decoded_t;

    decoded_t          awaited_symbols[$];
    int unsigned       mismatches;

    logic [CODE_W-1:0]  gather_bits;
    logic [4:0]         gather_len;
    logic [FIRST_W-1:0] first_code_of[LENGTH_SLOTS];
    logic [BYTE_W-1:0]  count_of[LENGTH_SLOTS];
    logic [BASE_W-1:0]  base_of[LENGTH_SLOTS];
    logic [BYTE_W-1:0]  symbol_mem[SYMBOL_COUNT];
    logic [POS_W-1:0]   fill_pos;
    logic [FIRST_W-1:0] running_first;
    logic [BASE_W-1:0]  running_base;

    function new();
      mismatches    = 0;
      gather_bits   = '0;
      gather_len    = '0;
      fill_pos      = '0;
      running_first = '0;
      running_base  = '0;
      for (int i = 0; i < LENGTH_SLOTS; i++) begin
        first_code_of[i] = '0;
        count_of[i]      = '0;
        base_of[i]       = '0;
      end
      for (int i = 0; i < SYMBOL_COUNT; i++) symbol_mem[i] = '0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Advance the mirrored state by one accepted beat.
    function void take_beat(table_beat_t b);
      int unsigned n, li, span, hit_idx, sum;
      decoded_t    res;
      if (b.op == OP_LOAD) begin
        gather_bits = '0;
        gather_len  = '0;
        if (b.restart_load) begin
          for (int i = 0; i < LENGTH_SLOTS; i++) begin
            first_code_of[i] = '0;
            count_of[i]      = '0;
            base_of[i]       = '0;
          end
          fill_pos      = '0;
          running_first = '0;
          running_base  = '0;
        end
        if (fill_pos < LENGTH_SLOTS) begin
          count_of[fill_pos]      = b.table_byte;
          first_code_of[fill_pos] = running_first;
          base_of[fill_pos]       = running_base;
          sum                     = running_first + b.table_byte;
          running_first           = FIRST_W'(sum << 1);
          running_base            = running_base + b.table_byte;
          fill_pos                = fill_pos + 1'b1;
        end else if (fill_pos < LENGTH_SLOTS + SYMBOL_COUNT) begin
          symbol_mem[fill_pos - LENGTH_SLOTS] = b.table_byte;
          fill_pos                            = fill_pos + 1'b1;
        end
        return;
      end
      gather_bits = {gather_bits[CODE_W-2:0], b.code_bit};
      n           = gather_len + 1;
      li          = (n - 1) % LENGTH_SLOTS;
      if (count_of[li] != 0 && gather_bits >= first_code_of[li]) begin
        span = gather_bits - first_code_of[li];
        if (span < count_of[li]) begin
          hit_idx     = base_of[li] + span;
          gather_bits = '0;
          gather_len  = '0;
          if (hit_idx < SYMBOL_COUNT) begin
            res.symbol = symbol_mem[hit_idx];
            res.error  = 1'b0;
          end else begin
            res.symbol = '0;
            res.error  = 1'b1;
          end
          awaited_symbols.push_back(res);
          return;
        end
      end
      if (n >= MAX_CODE_LENGTH) begin
        gather_bits = '0;
        gather_len  = '0;
        res.symbol  = '0;
        res.error   = 1'b1;
        awaited_symbols.push_back(res);
        return;
      end
      gather_len = 5'(n);
    endfunction

    task check_result(logic [BYTE_W-1:0] got_symbol, logic got_error);
      decoded_t want;
      if (awaited_symbols.size() == 0) begin
        report_mismatch($sformatf("symbol %0d error %0b with nothing awaited",
                                  got_symbol, got_error));
        return;
      end
      want = awaited_symbols.pop_front();
      if (got_symbol !== want.symbol)
        report_mismatch($sformatf("symbol %0d, expected %0d", got_symbol, want.symbol));
      if (got_error !== want.error)
        report_mismatch($sformatf("error %0b, expected %0b", got_error, want.error));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input holds a known value from time 0
  // --------------------------------------------------------------------------
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              push           = 1'b0;
  logic              full;
  logic              op_i           = OP_LOAD;
  logic              restart_load_i = 1'b0;
  logic [BYTE_W-1:0] table_byte_i   = '0;
  logic              code_bit_i     = 1'b0;
  logic              empty;
  logic              pop            = 1'b0;
  logic [BYTE_W-1:0] symbol_o;
  logic              error_o;

  chbd_symbol_scoreboard sb;

  int unsigned beat_idle_pct    = 0;  // chance the sender idles in a cycle
  int unsigned result_stall_pct = 0;  // chance the receiver stalls in a cycle
  int unsigned beats_sent       = 0;
  int unsigned quiet_cycles     = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  canonical_huffman_bit_decoder_unit #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_COUNT   (SYMBOL_COUNT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .restart_load_i(restart_load_i),
    .table_byte_i  (table_byte_i),
    .code_bit_i    (code_bit_i),
    .empty         (empty),
    .pop           (pop),
    .symbol_o      (symbol_o),
    .error_o       (error_o)
  );

  // Receiver: stall pop at random; pop may stay high while the queue is empty.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= result_stall_pct);
  end

  // Monitor: sample both handshakes at the edge, before this edge's drives land.
  // Note the input beat first so a same-edge result never races its prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full)
        sb.take_beat('{op: chbd_op_e'(op_i), restart_load: restart_load_i,
                       table_byte: table_byte_i, code_bit: code_bit_i});
      if (pop && !empty)
        sb.check_result(symbol_o, error_o);
    end
  end

  // Watchdog: end the run when neither side moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Idle at random, then hold one beat on the ports until it is taken.
  // Push stays high when the next beat follows straight away.
  task automatic drive_beat(input chbd_op_e op, input logic restart,
                            input logic [BYTE_W-1:0] tbyte, input logic cbit);
    while ($urandom_range(99) < beat_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    op_i           <= op;
    restart_load_i <= restart;
    table_byte_i   <= tbyte;
    code_bit_i     <= cbit;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // Load one table byte; the code bit is a don't-care, so randomize it.
  task automatic send_load(input logic restart, input logic [BYTE_W-1:0] tbyte);
    drive_beat(OP_LOAD, restart, tbyte, 1'($urandom_range(1)));
  endtask

  // Decode one bit; restart and table byte must be ignored, so randomize them.
  task automatic send_decode(input logic cbit);
    drive_beat(OP_DECODE, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)), cbit);
  endtask

  // Send the low len bits of a code, most significant first.
  task automatic send_code(input logic [CODE_W-1:0] code, input int unsigned len);
    for (int i = int'(len) - 1; i >= 0; i--) send_decode(code[i]);
  endtask

  // Drop push and hold off until every awaited symbol has come back.
  // Let the monitor note the last beat before checking what is still awaited.
  task automatic wait_until_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited_symbols.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Random rounds: mostly a canonical table followed by random code bits,
  // with oversubscribed tables, partial tables and plain noise mixed in.
  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned beat_goal);
    int unsigned stop_at, pick, room, take, budget, longest, total, n_counts, n_bits;
    int unsigned lens[LENGTH_SLOTS];
    beat_idle_pct    = idle_pct;
    result_stall_pct = stall_pct;
    stop_at          = beats_sent + beat_goal;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 90) begin
        if (pick < 75) begin
          // Build a canonical length profile: keep a few free nodes at each
          // level and spend them all at the longest length so most tables are
          // complete. Keep sizes small; only now and then fill all 256 slots.
          budget  = ($urandom_range(39) == 0) ? SYMBOL_COUNT : $urandom_range(2, 40);
          longest = ($urandom_range(4) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
          room    = 2;
          total   = 0;
          for (int l = 0; l < LENGTH_SLOTS; l++) begin
            take = 0;
            if (l + 1 == longest)
              take = room;
            else if (l + 1 < longest && $urandom_range(3) != 0)
              take = $urandom_range(room / 2, room - 1);
            if (take > budget - total) take = budget - total;
            if (take > 255) take = 255;
            lens[l] = take;
            total  += take;
            room    = (room - take) * 2;
          end
          // Partial table: stop after some counts and send no symbols.
          n_counts = (pick < 65) ? LENGTH_SLOTS : $urandom_range(1, LENGTH_SLOTS - 1);
          if (n_counts < LENGTH_SLOTS) total = 0;
        end else begin
          // Oversubscribed: counts far beyond what the code space holds.
          for (int l = 0; l < LENGTH_SLOTS; l++)
            lens[l] = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
          n_counts = LENGTH_SLOTS;
          total    = $urandom_range(0, 24);
        end
        for (int i = 0; i < n_counts; i++) send_load(i == 0, BYTE_W'(lens[i]));
        for (int i = 0; i < total; i++) send_load(1'b0, BYTE_W'($urandom_range(255)));
        // Random code bits, now and then broken by a stray load byte.
        n_bits = $urandom_range(16, 64);
        for (int i = 0; i < n_bits; i++) begin
          if ($urandom_range(39) == 0)
            send_load(1'b0, BYTE_W'($urandom_range(255)));
          else
            send_decode(1'($urandom_range(1)));
        end
      end else begin
        // Noise: any op, restarts anywhere, any byte.
        for (int i = 0; i < 12; i++)
          drive_beat(chbd_op_e'($urandom_range(1)), ($urandom_range(3) == 0),
                     BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh table after reset has no counts: sixteen bits give no match.
    send_code(16'hB6C5, 16);

    // Full table that writes every symbol slot: 254 codes of length 8 and
    // 4 of length 9. The last two length-9 codes point past the symbol range.
    for (int i = 0; i < LENGTH_SLOTS; i++)
      send_load(i == 0, (i == 7) ? 8'd254 : (i == 8) ? 8'd4 : 8'd0);
    for (int i = 0; i < SYMBOL_COUNT; i++) send_load(1'b0, BYTE_W'(255 - i));

    // Excess bytes past the table: ignored, position saturates.
    send_load(1'b0, 8'hFF);
    send_load(1'b0, 8'h00);
    send_load(1'b0, 8'h5A);

    // Partial code, then a load byte that throws it away.
    send_code(16'h0005, 3);
    send_load(1'b0, 8'hC3);
    send_code(16'h0000, 8);   // first length-8 code
    send_code(16'h01FD, 9);   // last in-range symbol slot
    send_code(16'h01FE, 9);   // slot just past the range
    send_code(16'h01FF, 9);   // last slot past the range
    send_code(16'h00FD, 8);   // last length-8 code

    // Random part, drained between phases so the sender pauses to empty.
    random_phase(0, 0, PHASE_BEATS);
    wait_until_drained();
    random_phase(77, 0, PHASE_BEATS);
    wait_until_drained();
    random_phase(0, 77, PHASE_BEATS);
    wait_until_drained();
    random_phase(22, 22, PHASE_BEATS);
    wait_until_drained();

    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
